[rtl/vertex_dedup_indexer_macros.svh]
// Assertion macros shared by the checkers of the vertex deduplication indexer.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef VERTEX_DEDUP_INDEXER_MACROS_SVH
`define VERTEX_DEDUP_INDEXER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VDI_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vertex_dedup_indexer: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define VDI_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vertex_dedup_indexer: next-cycle check failed");

`endif

[rtl/vdi_pkg.sv]
// Package for the vertex deduplication indexer: sizes, item and memory port types,
// and the coordinate compare helpers used by the hash and the coordinate store.
// No dependencies.
`default_nettype none

package vdi_pkg;

    // Table sizes.
    localparam int CAPACITY  = 4096;
    localparam int SLOTS     = 8192;

    localparam int COORD_W   = 64;
    localparam int OUT_IDX_W = 12;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int PRB_W     = $clog2(SLOTS + 1);

    // Multiplier of the slot hash (golden ratio, 32 bits).
    localparam logic [31:0] HASH_MUL = 32'h9E37_79B9;

    // One input item: a mesh corner.
    typedef struct packed {
        logic [COORD_W-1:0] x_bits;
        logic [COORD_W-1:0] y_bits;
        logic [COORD_W-1:0] z_bits;
        logic               end_of_face;
    } t_in;

    // One result item.
    typedef struct packed {
        logic [OUT_IDX_W-1:0] vertex_index;
        logic                 is_new;
        logic                 table_full;
        logic                 face_done;
    } t_out;

    // One slot of the hash table.
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } t_slot_entry;

    // Access to the slot table.
    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        t_slot_entry       wr_data;
    } t_slot_req;

    // Access to the coordinate stores; write data is the current corner.
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
    } t_coord_req;

    // Minus zero becomes plus zero.
    function automatic logic [COORD_W-1:0] fold_zero(input logic [COORD_W-1:0] b);
        return (b[COORD_W-2:0] == '0) ? '0 : b;
    endfunction

    function automatic logic is_nan64(input logic [COORD_W-1:0] b);
        return (b[62:52] == 11'h7FF) && (b[51:0] != '0);
    endfunction

    // IEEE equality on bit patterns: zeros match, a NaN matches nothing.
    function automatic logic coord_eq(input logic [COORD_W-1:0] a,
                                      input logic [COORD_W-1:0] b);
        return !is_nan64(a) && !is_nan64(b) && (fold_zero(a) == fold_zero(b));
    endfunction

    // Low bits of a vertex index as carried by the result item.
    function automatic logic [OUT_IDX_W-1:0] out_index(input logic [IDX_W-1:0] idx);
        logic [IDX_W+OUT_IDX_W-1:0] wide;
        wide = {{OUT_IDX_W{1'b0}}, idx};
        return wide[OUT_IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/vdi_channels.sv]
// Valid/ready channel interfaces for the corner input and the index result.
// Depends on vdi_pkg for the payload types.
`default_nettype none

interface vdi_in_if;
    import vdi_pkg::*;

    logic valid;
    logic ready;
    t_in  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface vdi_out_if;
    import vdi_pkg::*;

    logic valid;
    logic ready;
    t_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/vertex_dedup_indexer.sv]
// Vertex deduplication indexer: one result item per corner, one corner at a time.
// Each corner is hashed, then the table is probed slot by slot with a slot read, and a
// coordinate read for each occupied slot, until an empty slot, a match or exhaustion.
// A new corner is accepted only after the result of the last one is loaded for output.
// Reset is synchronous, active low; a clearing pass over all SLOTS (8192) slots then
// empties the slot table, and no corner is accepted until it ends.
`default_nettype none

module vertex_dedup_indexer (
    input  wire          i_clk,
    input  wire          i_rst_n,
    vdi_in_if.sink       i_in,
    vdi_out_if.source    o_out
);
    import vdi_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH_A,
        S_HASH_B,
        S_HASH_C,
        S_SLOT_CHK,
        S_CMP,
        S_DONE
    } t_state;

    t_state            r_state;
    t_in               r_item;
    logic [SLOT_W-1:0] r_pos;
    logic [PRB_W-1:0]  r_probes;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_res_idx;
    logic              r_res_new;
    logic              r_res_full;
    t_out              r_out;
    logic              r_out_valid;

    logic [SLOT_W-1:0] w_hash_pos;
    logic [SLOT_W-1:0] w_next_pos;
    logic [PRB_W-1:0]  w_probes_nx;
    logic              w_exhausted;
    logic              w_room;
    logic [IDX_W-1:0]  w_new_idx;
    logic              w_slot_ready;
    logic              w_match;
    logic              w_accept;
    logic              w_out_free;
    t_slot_entry       w_slot_rd;
    t_slot_req         w_slot_req;
    t_coord_req        w_coord_req;

    vdi_hash u_hash (
        .i_clk (i_clk),
        .i_key (r_item),
        .o_pos (w_hash_pos)
    );

    vdi_slot_mem u_slot_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_slot_req),
        .o_rd_data (w_slot_rd),
        .o_ready   (w_slot_ready)
    );

    vdi_coord_mem u_coord_mem (
        .i_clk   (i_clk),
        .i_req   (w_coord_req),
        .i_key   (r_item),
        .o_match (w_match)
    );

    // Probe bookkeeping: next slot with wrap-around and the exhaustion test.
    always_comb begin
        if (r_pos == SLOT_W'(SLOTS - 1)) begin
            w_next_pos = '0;
        end else begin
            w_next_pos = r_pos + SLOT_W'(1);
        end
        w_probes_nx = r_probes + PRB_W'(1);
        w_exhausted = (w_probes_nx == PRB_W'(SLOTS));
        w_room      = (r_count < CNT_W'(CAPACITY));
        w_new_idx   = r_count[IDX_W-1:0];
    end

    // Handshake terms.
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && w_slot_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Memory requests issued by the sequencer.
    always_comb begin
        w_slot_req  = '0;
        w_coord_req = '0;
        unique case (r_state)
            S_HASH_C: begin
                w_slot_req.rd_en   = 1'b1;
                w_slot_req.rd_addr = w_hash_pos;
            end
            S_SLOT_CHK: begin
                if (w_slot_rd.valid) begin
                    w_coord_req.rd_en   = 1'b1;
                    w_coord_req.rd_addr = w_slot_rd.idx;
                end else if (w_room) begin
                    w_slot_req.wr_en        = 1'b1;
                    w_slot_req.wr_addr      = r_pos;
                    w_slot_req.wr_data      = '{valid: 1'b1, idx: w_new_idx};
                    w_coord_req.wr_en       = 1'b1;
                    w_coord_req.wr_addr     = w_new_idx;
                end
            end
            S_CMP: begin
                if (!w_match && !w_exhausted) begin
                    w_slot_req.rd_en   = 1'b1;
                    w_slot_req.rd_addr = w_next_pos;
                end
            end
            S_IDLE, S_HASH_A, S_HASH_B, S_DONE: begin
            end
        endcase
    end

    // Sequencer: hash, probe slot by slot, then insert or report, then hand off.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A taken result is cleared here unless a new one is loaded below.
            if (r_out_valid && o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_item   <= i_in.data;
                        r_probes <= '0;
                        r_state  <= S_HASH_A;
                    end
                end
                S_HASH_A: begin
                    r_state <= S_HASH_B;
                end
                S_HASH_B: begin
                    r_state <= S_HASH_C;
                end
                S_HASH_C: begin
                    r_pos   <= w_hash_pos;
                    r_state <= S_SLOT_CHK;
                end
                S_SLOT_CHK: begin
                    priority if (w_slot_rd.valid) begin
                        r_state <= S_CMP;
                    end else if (w_room) begin
                        r_res_idx  <= w_new_idx;
                        r_res_new  <= 1'b1;
                        r_res_full <= 1'b0;
                        r_count    <= r_count + CNT_W'(1);
                        r_state    <= S_DONE;
                    end else begin
                        r_res_idx  <= '0;
                        r_res_new  <= 1'b0;
                        r_res_full <= 1'b1;
                        r_state    <= S_DONE;
                    end
                end
                S_CMP: begin
                    // The slot read data holds, so it still names the compared entry.
                    priority if (w_match) begin
                        r_res_idx  <= w_slot_rd.idx;
                        r_res_new  <= 1'b0;
                        r_res_full <= 1'b0;
                        r_state    <= S_DONE;
                    end else if (w_exhausted) begin
                        r_res_idx  <= '0;
                        r_res_new  <= 1'b0;
                        r_res_full <= 1'b1;
                        r_state    <= S_DONE;
                    end else begin
                        r_pos    <= w_next_pos;
                        r_probes <= w_probes_nx;
                        r_state  <= S_SLOT_CHK;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out.vertex_index <= out_index(r_res_idx);
                        r_out.is_new       <= r_res_new;
                        r_out.table_full   <= r_res_full;
                        r_out.face_done    <= r_item.end_of_face;
                        r_out_valid        <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/vdi_hash.sv]
// Two-stage slot hash of a corner: coordinate mix, then a 32-bit multiply,
// then a reduction into the slot range. Depends on vdi_pkg.
`default_nettype none

module vdi_hash (
    input  wire                       i_clk,
    input  vdi_pkg::t_in              i_key,
    output logic [vdi_pkg::SLOT_W-1:0] o_pos
);
    import vdi_pkg::*;

    logic [COORD_W-1:0] w_fx;
    logic [COORD_W-1:0] w_fy;
    logic [COORD_W-1:0] w_fz;
    logic [COORD_W-1:0] w_mix;
    logic [31:0]        r_h32;
    logic [31:0]        r_prod;
    logic [SLOT_W-1:0]  w_top;
    logic [SLOT_W:0]    w_top_ext;
    logic [SLOT_W:0]    w_red;

    // Mix the three coordinates with zeros folded, so that +0 and -0 hash alike.
    always_comb begin
        w_fx  = fold_zero(i_key.x_bits);
        w_fy  = fold_zero(i_key.y_bits);
        w_fz  = fold_zero(i_key.z_bits);
        w_mix = w_fx ^ {w_fy[42:0], w_fy[63:43]} ^ {w_fz[20:0], w_fz[63:21]};
    end

    // Stage registers: folded mix, then the multiplicative scramble.
    always_ff @(posedge i_clk) begin
        r_h32  <= w_mix[63:32] ^ w_mix[31:0];
        r_prod <= r_h32 * HASH_MUL;
    end

    // The top bits are below twice the slot count, so one subtract reduces them.
    always_comb begin
        w_top     = r_prod[31 -: SLOT_W];
        w_top_ext = {1'b0, w_top};
        if (w_top_ext >= (SLOT_W + 1)'(SLOTS)) begin
            w_red = w_top_ext - (SLOT_W + 1)'(SLOTS);
        end else begin
            w_red = w_top_ext;
        end
        o_pos = w_red[SLOT_W-1:0];
    end

endmodule

`default_nettype wire

[rtl/vdi_slot_mem.sv]
// Hash slot table: one synchronous memory with registered read data and a
// clearing pass after reset that marks every slot empty. Depends on vdi_pkg.
`default_nettype none

module vdi_slot_mem (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  vdi_pkg::t_slot_req   i_req,
    output vdi_pkg::t_slot_entry o_rd_data,
    output logic                 o_ready
);
    import vdi_pkg::*;

    t_slot_entry       r_mem [SLOTS];
    t_slot_entry       r_rd_data;
    logic              r_clearing;
    logic [SLOT_W-1:0] r_clr_addr;

    // Clearing pass: one slot per cycle from address zero to the last slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == SLOT_W'(SLOTS - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + SLOT_W'(1);
        end
    end

    // Single write port shared by the clearing pass and the lookup logic.
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Registered read; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = !r_clearing;

endmodule

`default_nettype wire

[rtl/vdi_coord_mem.sv]
// Coordinate stores of the unique vertices and the IEEE equality compare of a
// stored vertex against the current corner. Depends on vdi_pkg.
`default_nettype none

module vdi_coord_mem (
    input  wire                 i_clk,
    input  vdi_pkg::t_coord_req i_req,
    input  vdi_pkg::t_in        i_key,
    output logic                o_match
);
    import vdi_pkg::*;

    logic [COORD_W-1:0] r_x_store [CAPACITY];
    logic [COORD_W-1:0] r_y_store [CAPACITY];
    logic [COORD_W-1:0] r_z_store [CAPACITY];
    logic [COORD_W-1:0] r_x_rd;
    logic [COORD_W-1:0] r_y_rd;
    logic [COORD_W-1:0] r_z_rd;

    // A new vertex is written at its index in all three stores at once.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_x_store[i_req.wr_addr] <= i_key.x_bits;
            r_y_store[i_req.wr_addr] <= i_key.y_bits;
            r_z_store[i_req.wr_addr] <= i_key.z_bits;
        end
    end

    // Registered read of the vertex named by a valid slot.
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_x_rd <= r_x_store[i_req.rd_addr];
            r_y_rd <= r_y_store[i_req.rd_addr];
            r_z_rd <= r_z_store[i_req.rd_addr];
        end
    end

    // Per-coordinate IEEE equality against the corner being looked up.
    assign o_match = coord_eq(r_x_rd, i_key.x_bits) &&
                     coord_eq(r_y_rd, i_key.y_bits) &&
                     coord_eq(r_z_rd, i_key.z_bits);

endmodule

`default_nettype wire

[rtl/vdi_checker.sv]
// Port-level checker for the vertex deduplication indexer, bound to the top level.
// Depends on vdi_pkg and the assertion macros header.
`default_nettype none

`include "vertex_dedup_indexer_macros.svh"

module vdi_checker (
    input wire           i_clk,
    input wire           i_rst_n,
    input wire           i_in_valid,
    input wire           i_in_ready,
    input wire           i_out_valid,
    input wire           i_out_ready,
    input vdi_pkg::t_out i_out_data
);
    import vdi_pkg::*;

    // A result that waits keeps its payload.
    `VDI_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))

    // The block works on one corner at a time: no accept right after an accept.
    `VDI_ASSERT_NEXT(a_one_in_flight, i_in_valid && i_in_ready, !i_in_ready)

    // A vertex is either newly stored or rejected for lack of room, never both.
    `VDI_ASSERT_IMPL(a_new_xor_full, i_out_valid, !(i_out_data.is_new && i_out_data.table_full))

    // A rejected vertex reports index zero.
    `VDI_ASSERT_IMPL(a_full_index, i_out_valid && i_out_data.table_full, i_out_data.vertex_index == '0)

endmodule

bind vertex_dedup_indexer vdi_checker u_vdi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

`default_nettype wire
